/* rtl/core/dtai_pkg.sv */
package dtai_pkg;

	// Address and arithmetic widths
	localparam int unsigned ADDR_W      = 20;
	localparam int unsigned NUM_W       = 21;
	localparam int unsigned HOST_W      = 32;
	localparam int unsigned INVAL_W     = 18;
	localparam int unsigned BLK_W       = 7;
	localparam int unsigned RECIP_SHIFT = 22;
	localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
	localparam int unsigned PROD_W      = NUM_W + RECIP_W;

	// Descriptor queue geometry
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = 2;

	// Ring memory constants
	localparam logic [NUM_W-1:0]  MEM_SIZE  = 21'h100000;
	localparam logic [ADDR_W-1:0] READ_GAP  = 20'h00020;
	localparam logic [ADDR_W-1:0] WRITE_GAP = 20'h00001;

	// Stream field layout
	localparam int unsigned IN_DATA_W  = 72;
	localparam int unsigned IN_USER_W  = 2;
	localparam int unsigned OUT_DATA_W = 112;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		CFG_EN_A   = 2'd0,
		CFG_ADDR_A = 2'd1,
		CFG_EN_B   = 2'd2,
		CFG_ADDR_B = 2'd3
	} cfg_idx_t;

	// Interrupt setup shared with the back end
	typedef struct packed {
		logic              en_a;
		logic [ADDR_W-1:0] addr_a;
		logic              en_b;
		logic [ADDR_W-1:0] addr_b;
	} irq_cfg_t;

	// Classified transfer descriptor
	typedef struct packed {
		logic [ADDR_W-1:0] next_start;
		logic [ADDR_W-1:0] start;
		logic [NUM_W-1:0]  end_lim;
		logic              wrap;
		logic              xfer;
		logic              write;
		logic              short_wr;
		logic [ADDR_W-1:0] count;
		logic [HOST_W-1:0] host;
	} desc_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

/* rtl/core/dtai_front.sv */
module dtai_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [dtai_pkg::IN_DATA_W-1:0] in_data,
	input  logic [dtai_pkg::IN_USER_W-1:0] in_user,
	input  dtai_pkg::q_status_t            q_status,
	output logic                           push,
	output dtai_pkg::desc_t                push_desc
);
	import dtai_pkg::*;

	logic [ADDR_W-1:0] start_q;
	logic [ADDR_W-1:0] new_start;
	logic [ADDR_W-1:0] count;
	logic [HOST_W-1:0] host;
	cmd_t              cmd;
	logic [NUM_W-1:0]  end_sum;
	logic              wrap;
	logic              short_wr;
	logic [ADDR_W-1:0] gap;
	logic [ADDR_W-1:0] tda;

	// Unpack the incoming transaction
	assign cmd       = cmd_t'(in_user);
	assign new_start = in_data[19:0];
	assign count     = in_data[39:20];
	assign host      = in_data[71:40];

	assign in_ready = !q_status.full;
	assign push     = in_valid && in_ready;

	// Transfer end, wrap and next start address
	assign end_sum  = {1'b0, start_q} + {1'b0, count};
	assign wrap     = end_sum > MEM_SIZE;
	assign short_wr = (cmd == CMD_WRITE) && (count < ADDR_W'(2));
	assign gap      = (cmd == CMD_WRITE) ? WRITE_GAP : READ_GAP;
	assign tda      = start_q + count + gap;

	// Classify the command into a descriptor
	always_comb begin
		push_desc          = '0;
		push_desc.start    = start_q;
		push_desc.count    = count;
		push_desc.host     = host;
		push_desc.wrap     = wrap;
		push_desc.end_lim  = wrap ? MEM_SIZE : end_sum;
		push_desc.next_start = start_q;
		unique case (cmd)
			CMD_LOAD: begin
				push_desc.next_start = new_start;
			end
			CMD_WRITE: begin
				push_desc.short_wr = short_wr;
				if (!short_wr) begin
					push_desc.xfer       = 1'b1;
					push_desc.write      = 1'b1;
					push_desc.next_start = tda;
				end
			end
			CMD_READ: begin
				push_desc.xfer       = 1'b1;
				push_desc.next_start = tda;
			end
			CMD_NONE: begin
				push_desc.next_start = start_q;
			end
			default: begin
				push_desc.next_start = start_q;
			end
		endcase
	end

	// Load the next start address on every accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
		end else if (push) begin
			start_q <= push_desc.next_start;
		end
	end

`ifndef NO_ASSERTIONS
	a_load_sets_start: assert property (@(posedge clk) disable iff (!arst_n)
		(push && cmd == CMD_LOAD) |=> (start_q == $past(new_start)))
		else $error("load did not set the start address");

	a_short_write_keeps_start: assert property (@(posedge clk) disable iff (!arst_n)
		(push && short_wr) |=> $stable(start_q))
		else $error("short write moved the start address");
`endif

endmodule

/* rtl/core/dtai_queue.sv */
module dtai_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  dtai_pkg::desc_t     push_desc,
	input  logic                pop,
	output dtai_pkg::desc_t     pop_desc,
	output dtai_pkg::q_status_t status
);
	import dtai_pkg::*;

	desc_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign pop_desc     = entry_q[rd_ptr_q];
	assign status.full  = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign status.empty = count_q == '0;

	// Store descriptors
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	// Move pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10: count_q <= count_q + (QPTR_W+1)'(1);
				2'b01: count_q <= count_q - (QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q <= (QPTR_W+1)'(QUEUE_DEPTH)) && !(pop && status.empty))
		else $error("descriptor queue over- or underflow");
`endif

endmodule

/* rtl/core/dtai_back.sv */
module dtai_back #(
	parameter int unsigned WORDS_PER_BLOCK = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  dtai_pkg::irq_cfg_t              irq_cfg,
	input  dtai_pkg::q_status_t             q_status,
	input  dtai_pkg::desc_t                 pop_desc,
	output logic                            pop,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [dtai_pkg::OUT_DATA_W-1:0] out_data
);
	import dtai_pkg::*;

	localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'((1 << RECIP_SHIFT) / WORDS_PER_BLOCK);
	localparam logic [BLK_W-1:0]   BLK    = BLK_W'(WORDS_PER_BLOCK);
	localparam logic [NUM_W-1:0]   BLK_M1 = NUM_W'(WORDS_PER_BLOCK - 1);

	// Stage 1: interrupt compares, host end, reciprocal products
	logic              vld_s1;
	logic              hit_a_s1, hit_b_s1, wrap_s1, write_s1;
	logic [ADDR_W-1:0] next_s1;
	logic [ADDR_W-1:0] countdown_s1;
	logic [HOST_W-1:0] host_end_s1;
	logic [NUM_W-1:0]  num_first_s1, num_end_s1;
	logic [PROD_W-1:0] prod_first_s1, prod_end_s1;

	// Stage 2: corrected quotients
	logic               vld_s2;
	logic               hit_a_s2, hit_b_s2, wrap_s2, write_s2;
	logic [ADDR_W-1:0]  next_s2;
	logic [ADDR_W-1:0]  countdown_s2;
	logic [HOST_W-1:0]  host_end_s2;
	logic [INVAL_W-1:0] inval_first_s2, inval_end_s2;

	// Stage 3: output register
	logic               vld_s3;
	logic [OUT_DATA_W-1:0] data_s3;

	logic rdy_s1, rdy_s2, rdy_s3;

	logic              hit_a, hit_b;
	logic [NUM_W-1:0]  num_end;
	logic [NUM_W-1:0]  q0_first, q0_end;
	logic [NUM_W+BLK_W-1:0] qw_first, qw_end;
	logic [NUM_W-1:0]  r_first, r_end;
	logic [NUM_W-1:0]  q_first, q_end;

	// Stall chain from the output backward
	assign rdy_s3 = !vld_s3 || out_ready;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;
	assign pop    = rdy_s1 && !q_status.empty;

	// Address interrupt tests over (start, next], OR-ed when wrapped
	always_comb begin
		hit_a = 1'b0;
		hit_b = 1'b0;
		if (pop_desc.xfer) begin
			if (pop_desc.wrap) begin
				hit_a = irq_cfg.en_a && ((irq_cfg.addr_a > pop_desc.start) ||
					(irq_cfg.addr_a <= pop_desc.next_start));
				hit_b = irq_cfg.en_b && ((irq_cfg.addr_b > pop_desc.start) ||
					(irq_cfg.addr_b <= pop_desc.next_start));
			end else begin
				hit_a = irq_cfg.en_a && (irq_cfg.addr_a > pop_desc.start) &&
					(irq_cfg.addr_a <= pop_desc.next_start);
				hit_b = irq_cfg.en_b && (irq_cfg.addr_b > pop_desc.start) &&
					(irq_cfg.addr_b <= pop_desc.next_start);
			end
		end
	end

	assign num_end = pop_desc.end_lim + BLK_M1;

	always_ff @(posedge clk) begin
		if (pop) begin
			hit_a_s1      <= hit_a;
			hit_b_s1      <= hit_b;
			wrap_s1       <= pop_desc.xfer && pop_desc.wrap;
			write_s1      <= pop_desc.write;
			next_s1       <= pop_desc.next_start;
			countdown_s1  <= pop_desc.xfer ? pop_desc.count :
				(pop_desc.short_wr ? ADDR_W'(1) : '0);
			host_end_s1   <= pop_desc.xfer ?
				pop_desc.host + {11'b0, pop_desc.count, 1'b0} : '0;
			num_first_s1  <= {1'b0, pop_desc.start};
			num_end_s1    <= num_end;
			prod_first_s1 <= PROD_W'({1'b0, pop_desc.start}) * PROD_W'(RECIP);
			prod_end_s1   <= PROD_W'(num_end) * PROD_W'(RECIP);
		end
	end

	// Quotient estimate is exact or one low; fix it with the remainder
	assign q0_first = prod_first_s1[RECIP_SHIFT +: NUM_W];
	assign q0_end   = prod_end_s1[RECIP_SHIFT +: NUM_W];
	assign qw_first = (NUM_W+BLK_W)'(q0_first) * (NUM_W+BLK_W)'(BLK);
	assign qw_end   = (NUM_W+BLK_W)'(q0_end) * (NUM_W+BLK_W)'(BLK);
	assign r_first  = num_first_s1 - qw_first[NUM_W-1:0];
	assign r_end    = num_end_s1 - qw_end[NUM_W-1:0];
	assign q_first  = (r_first >= NUM_W'(BLK)) ? q0_first + NUM_W'(1) : q0_first;
	assign q_end    = (r_end >= NUM_W'(BLK)) ? q0_end + NUM_W'(1) : q0_end;

	always_ff @(posedge clk) begin
		if (vld_s1 && rdy_s2) begin
			hit_a_s2       <= hit_a_s1;
			hit_b_s2       <= hit_b_s1;
			wrap_s2        <= wrap_s1;
			write_s2       <= write_s1;
			next_s2        <= next_s1;
			countdown_s2   <= countdown_s1;
			host_end_s2    <= host_end_s1;
			inval_first_s2 <= write_s1 ? q_first[INVAL_W-1:0] : '0;
			inval_end_s2   <= write_s1 ? q_end[INVAL_W-1:0] : '0;
		end
	end

	// Pack the result transaction
	always_ff @(posedge clk) begin
		if (vld_s2 && rdy_s3) begin
			data_s3 <= {host_end_s2, countdown_s2, write_s2, inval_end_s2,
				inval_first_s2, wrap_s2, hit_b_s2, hit_a_s2, next_s2};
		end
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= pop;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy_s3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	assign out_valid = vld_s3;
	assign out_data  = data_s3;

`ifndef NO_ASSERTIONS
	a_first_residue: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (r_first < NUM_W'(2 * WORDS_PER_BLOCK)))
		else $error("first block quotient estimate out of range");

	a_end_residue: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (r_end < NUM_W'(2 * WORDS_PER_BLOCK)))
		else $error("end block quotient estimate out of range");

	a_inval_write_only: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !write_s2) |-> (inval_first_s2 == '0 && inval_end_s2 == '0))
		else $error("invalidation range on a non-write");
`endif

endmodule

/* rtl/core/dma_transfer_address_irq_core.sv */
// The start address updates in the accept cycle; the item is queued, then staged in s1 to s3.
// Throughput: one transaction per cycle while the queue is not full.
// A 4-entry descriptor queue separates the front classifier from the 3-stage back end.
// Reset (arst_n low, asynchronous): start address, interrupt setup, queue and stage
// valid bits clear; no result is pending and the block accepts at once after reset.
module dma_transfer_address_irq_core #(
	parameter int unsigned WORDS_PER_BLOCK = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	// Input stream
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [71:0]  s_axis_tdata,   // new_start[19:0], word_count[39:20], host_address[71:40]
	input  logic [1:0]   s_axis_tuser,   // command[1:0]
	// Result stream
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [111:0] m_axis_tdata,   // next_start[19:0], irq_hit_a[20], irq_hit_b[21],
	                                     // wrapped[22], inval_first[40:23], inval_end[58:41],
	                                     // inval_valid[59], irq_countdown[79:60],
	                                     // host_end[111:80]
	// Configuration write port
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [19:0]  cfg_wdata
);
	import dtai_pkg::*;

	irq_cfg_t  irq_cfg_q;
	q_status_t q_status;
	desc_t     push_desc;
	desc_t     pop_desc;
	logic      push;
	logic      pop;

	// Interrupt setup registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_EN_A:   irq_cfg_q.en_a   <= cfg_wdata[0];
				CFG_ADDR_A: irq_cfg_q.addr_a <= cfg_wdata;
				CFG_EN_B:   irq_cfg_q.en_b   <= cfg_wdata[0];
				CFG_ADDR_B: irq_cfg_q.addr_b <= cfg_wdata;
				default:    irq_cfg_q        <= irq_cfg_q;
			endcase
		end
	end

	dtai_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.q_status  (q_status),
		.push      (push),
		.push_desc (push_desc)
	);

	dtai_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.pop_desc  (pop_desc),
		.status    (q_status)
	);

	dtai_back #(
		.WORDS_PER_BLOCK (WORDS_PER_BLOCK)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.irq_cfg   (irq_cfg_q),
		.q_status  (q_status),
		.pop_desc  (pop_desc),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

/* bench/dtai_checker.sv */
`timescale 1ns / 1ps

module dtai_checker #(
	parameter int unsigned WORDS_PER_BLOCK = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [71:0]  s_axis_tdata,   // new_start[19:0], word_count[39:20], host_address[71:40]
	input  logic [1:0]   s_axis_tuser,   // command[1:0]
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [111:0] m_axis_tdata,   // next_start, irq_hit_a, irq_hit_b, wrapped,
	                                     // inval_first, inval_end, inval_valid,
	                                     // irq_countdown, host_end
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [19:0]  cfg_wdata,
	output int           outstanding,
	output int           errors
);

	// Result layout, lowest field last
	typedef struct packed {
		logic [31:0] host_end;
		logic [19:0] irq_countdown;
		logic        inval_valid;
		logic [17:0] inval_end;
		logic [17:0] inval_first;
		logic        wrapped;
		logic        irq_hit_b;
		logic        irq_hit_a;
		logic [19:0] next_start;
	} transfer_res_t;

	// Mirror of the block state and interrupt setup
	bit [19:0] ring_start;
	bit        irq_en_a;
	bit [19:0] irq_addr_a;
	bit        irq_en_b;
	bit [19:0] irq_addr_b;

	transfer_res_t transfer_q[$];

	task automatic report(string msg);
		$display("%0t checker: mismatch, %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(string name, longint unsigned got_v, longint unsigned want_v);
		if (got_v != want_v) begin
			report($sformatf("%s: got 0x%0h, expected 0x%0h", name, got_v, want_v));
		end
	endtask

	// Interrupt address passed within (from, to], as an OR once the range wraps
	function automatic logic addr_passed(logic en, logic [19:0] irq, logic [19:0] from,
			logic [19:0] to, logic wrap);
		if (!en) return 1'b0;
		if (wrap) return (irq > from) || (irq <= to);
		return (irq > from) && (irq <= to);
	endfunction

	// Work out the result of one command from the current start address
	function automatic transfer_res_t compute_transfer(dtai_pkg::cmd_t cmd, logic [19:0] start,
			logic [19:0] nstart, logic [19:0] count, logic [31:0] host);
		transfer_res_t r;
		int unsigned end_sum, base, gap, lim;
		logic [19:0] nxt;
		logic wrap;
		r = '0;
		case (cmd)
			dtai_pkg::CMD_LOAD: r.next_start = nstart;
			dtai_pkg::CMD_NONE: r.next_start = start;
			default: begin
				if (cmd == dtai_pkg::CMD_WRITE && count < 2) begin
					// Short write: nothing moves, countdown only
					r.next_start = start;
					r.irq_countdown = 20'd1;
				end else begin
					end_sum = start + count;
					wrap = end_sum > dtai_pkg::MEM_SIZE;
					gap = (cmd == dtai_pkg::CMD_WRITE) ? dtai_pkg::WRITE_GAP : dtai_pkg::READ_GAP;
					base = wrap ? end_sum - dtai_pkg::MEM_SIZE : end_sum;
					nxt = 20'(base + gap);
					lim = wrap ? dtai_pkg::MEM_SIZE : end_sum;
					r.irq_hit_a = addr_passed(irq_en_a, irq_addr_a, start, nxt, wrap);
					r.irq_hit_b = addr_passed(irq_en_b, irq_addr_b, start, nxt, wrap);
					r.wrapped = wrap;
					if (cmd == dtai_pkg::CMD_WRITE) begin
						r.inval_first = 18'(start / WORDS_PER_BLOCK);
						r.inval_end = 18'((lim + WORDS_PER_BLOCK - 1) / WORDS_PER_BLOCK);
						r.inval_valid = 1'b1;
					end
					r.irq_countdown = count;
					r.host_end = host + {count, 1'b0};
					r.next_start = nxt;
				end
			end
		endcase
		return r;
	endfunction

	// Track config writes, predict on input transactions, compare result transactions
	always @(posedge clk or negedge arst_n) begin : watch
		transfer_res_t want;
		transfer_res_t got;
		if (!arst_n) begin
			ring_start = '0;
			irq_en_a = 1'b0;
			irq_addr_a = '0;
			irq_en_b = 1'b0;
			irq_addr_b = '0;
			transfer_q.delete();
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (dtai_pkg::cfg_idx_t'(cfg_index))
					dtai_pkg::CFG_EN_A:   irq_en_a = cfg_wdata[0];
					dtai_pkg::CFG_ADDR_A: irq_addr_a = cfg_wdata;
					dtai_pkg::CFG_EN_B:   irq_en_b = cfg_wdata[0];
					dtai_pkg::CFG_ADDR_B: irq_addr_b = cfg_wdata;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				want = compute_transfer(dtai_pkg::cmd_t'(s_axis_tuser), ring_start,
					s_axis_tdata[19:0], s_axis_tdata[39:20], s_axis_tdata[71:40]);
				ring_start = want.next_start;
				transfer_q.push_back(want);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (transfer_q.size() == 0) begin
					report($sformatf("result with none expected, data 0x%0h", m_axis_tdata));
				end else begin
					want = transfer_q.pop_front();
					check_field("next_start", got.next_start, want.next_start);
					check_field("irq_hit_a", got.irq_hit_a, want.irq_hit_a);
					check_field("irq_hit_b", got.irq_hit_b, want.irq_hit_b);
					check_field("wrapped", got.wrapped, want.wrapped);
					check_field("inval_first", got.inval_first, want.inval_first);
					check_field("inval_end", got.inval_end, want.inval_end);
					check_field("inval_valid", got.inval_valid, want.inval_valid);
					check_field("irq_countdown", got.irq_countdown, want.irq_countdown);
					check_field("host_end", got.host_end, want.host_end);
				end
			end
			outstanding = transfer_q.size();
		end
	end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import dtai_pkg::*;

	localparam int unsigned WPB = 8;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [71:0]  s_axis_tdata = '0;   // new_start[19:0], word_count[39:20], host_address[71:40]
	logic [1:0]   s_axis_tuser = '0;   // command[1:0]
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [111:0] m_axis_tdata;        // next_start[19:0] up to host_end[111:80]
	logic         cfg_we = 1'b0;
	logic [1:0]   cfg_index = '0;
	logic [19:0]  cfg_wdata = '0;

	int outstanding;
	int errors;

	// Stimulus controls; calm and the hold flags are shared with the result sink
	bit calm;
	bit hold_req;
	bit hold_served;
	bit tx_gaps;
	logic [19:0] aim_a = '0;
	logic [19:0] aim_b = '0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	dma_transfer_address_irq_core #(
		.WORDS_PER_BLOCK(WPB)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	dtai_checker #(
		.WORDS_PER_BLOCK(WPB)
	) u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.outstanding(outstanding),
		.errors(errors)
	);

	// Offer one command and hold it until the transaction completes
	task automatic send_item(cmd_t cmd, logic [19:0] nstart, logic [19:0] count,
			logic [31:0] host);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {host, count, nstart};
		do @(posedge clk); while (!s_axis_tready);
		if (tx_gaps && !calm && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	// Stop offering and wait until every expected result is back
	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [19:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
	endtask

	// Load all interrupt registers while the block is idle
	task automatic configure(bit en_a, logic [19:0] addr_a, bit en_b, logic [19:0] addr_b);
		wait_drain();
		write_reg(CFG_EN_A, {19'($urandom), en_a});
		write_reg(CFG_ADDR_A, addr_a);
		write_reg(CFG_EN_B, {19'($urandom), en_b});
		write_reg(CFG_ADDR_B, addr_b);
		cfg_we <= 1'b0;
		aim_a = addr_a;
		aim_b = addr_b;
	endtask

	// Random command, with start loads aimed near the interrupt addresses and memory top
	task automatic send_random();
		cmd_t cmd;
		logic [19:0] nstart;
		logic [19:0] count;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 15) cmd = CMD_LOAD;
		else if (pick < 55) cmd = CMD_WRITE;
		else if (pick < 95) cmd = CMD_READ;
		else cmd = CMD_NONE;
		case ($urandom_range(0, 3))
			0: nstart = 20'($urandom);
			1: nstart = aim_a - 20'($urandom_range(0, 64));
			2: nstart = aim_b - 20'($urandom_range(0, 64));
			default: nstart = 20'hfffff - 20'($urandom_range(0, 255));
		endcase
		case ($urandom_range(0, 9))
			0, 1: count = 20'($urandom_range(0, 3));
			2, 3, 4, 5: count = 20'($urandom_range(0, 1023));
			6, 7: count = 20'($urandom);
			8: count = 20'hfffff - 20'($urandom_range(0, 255));
			default: count = 20'($urandom_range(0, 32767));
		endcase
		send_item(cmd, nstart, count, $urandom);
	endtask

	// Result sink: random stall bursts, one long hold-off on request, none at the end
	initial begin : result_sink
		int unsigned cyc;
		cyc = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (hold_req && !hold_served) begin
				m_axis_tready <= 1'b0;
				repeat (60) @(posedge clk);
				hold_served = 1'b1;
				m_axis_tready <= 1'b1;
			end else if (!calm && (cyc % 500) < 300 && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int unsigned i;
		int unsigned phase;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pass: short writes, exact end of memory, wraps, extremes
		tx_gaps = 1'b1;
		configure(1'b1, 20'h00010, 1'b1, 20'hfffff);
		send_item(CMD_LOAD, 20'h00000, 20'h00000, 32'h0000_0000);
		send_item(CMD_WRITE, 20'hfffff, 20'h00000, 32'hffff_ffff);
		send_item(CMD_WRITE, 20'h00000, 20'h00001, 32'h1234_5678);
		send_item(CMD_WRITE, 20'h00000, 20'h00002, 32'h0000_0100);
		send_item(CMD_READ, 20'h00000, 20'h00000, 32'h0000_0200);
		send_item(CMD_READ, 20'h00000, 20'h00001, 32'h8000_0000);
		send_item(CMD_LOAD, 20'hfff00, 20'h00000, 32'h0000_0000);
		send_item(CMD_WRITE, 20'h00000, 20'h00100, 32'h0000_0000);
		send_item(CMD_LOAD, 20'hfff00, 20'hfffff, 32'hffff_ffff);
		send_item(CMD_READ, 20'h00000, 20'h00101, 32'h0000_0000);
		send_item(CMD_LOAD, 20'hfffff, 20'h00000, 32'h0000_0000);
		send_item(CMD_WRITE, 20'h00000, 20'hfffff, 32'hffff_ffff);
		send_item(CMD_READ, 20'h00000, 20'hfffff, 32'hffff_fffe);
		send_item(CMD_NONE, 20'hfffff, 20'hfffff, 32'hffff_ffff);
		send_item(CMD_NONE, 20'h00000, 20'h00000, 32'h0000_0000);
		send_item(CMD_LOAD, 20'h00000, 20'h00000, 32'h0000_0000);
		send_item(CMD_WRITE, 20'h00000, 20'hfffff, 32'h0000_0001);
		send_item(CMD_LOAD, 20'hfffff, 20'hfffff, 32'hffff_ffff);
		send_item(CMD_READ, 20'hfffff, 20'hfffff, 32'h0000_0000);
		send_item(CMD_WRITE, 20'h00007, 20'h00007, 32'h7fff_ffff);

		// Random phases, each under its own interrupt setup
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: configure(1'b1, 20'h00000, 1'b1, 20'hfffff);
				1: configure(1'b1, 20'($urandom), 1'b0, 20'($urandom));
				2: configure(1'b0, 20'($urandom), 1'b1, 20'($urandom));
				3: configure(1'b0, 20'hfffff, 1'b0, 20'h00000);
				default: configure(1'b1, 20'($urandom), 1'b1, 20'($urandom));
			endcase
			if (phase == 2) begin
				// Back up the queue against a long receiver hold-off
				tx_gaps = 1'b0;
				hold_req = 1'b1;
				repeat (30) send_random();
			end
			if (phase == 5) calm = 1'b1;
			for (i = 0; i < 180; i++) begin
				tx_gaps = (i % 60) < 40;
				send_random();
			end
		end

		wait_drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && outstanding == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Hard stop well past the slowest correct run
	initial begin : watchdog
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
